// ===== rtl/dacs_pkg.sv =====
package dacs_pkg;

    localparam int WINDOW_DEF           = 16;
    localparam int STORE_DEPTH_DEF      = 32;
    localparam int DIES_DEF             = 8;
    localparam int CHANNELS_DEF         = 4;
    localparam int SECTORS_PER_PAGE_DEF = 8;

    localparam int SECTOR_W = 32;
    localparam int ENTRY_W  = 56;

    typedef enum logic [1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_ISSUED   = 2'd1,
        STAT_NONE     = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic         func;
        logic [7:0]   cmd_code;
        logic [31:0]  sector_addr;
        logic [7:0]   sector_count;
        logic [7:0]   tag;
        logic [7:0]   die_busy;
    } cmd_item_t;

    typedef struct packed {
        status_t      status;
        logic [7:0]   out_cmd_code;
        logic [31:0]  out_sector_addr;
        logic [7:0]   out_sector_count;
        logic [7:0]   out_tag;
        logic [2:0]   out_die;
        logic [5:0]   queue_length;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0]   op;
        logic [31:0]  sector;
        logic [7:0]   count;
        logic [7:0]   tag;
    } entry_t;

    localparam logic [0:0] FUNC_ENQUEUE = 1'b0;
    localparam logic [0:0] FUNC_ISSUE   = 1'b1;

endpackage

// ===== rtl/die_aware_command_scheduler.sv =====
// enqueue: result after the die calculation (sector, page, quotient and die registers), then the memory write
// issue: window entries are examined one at a time, then each younger entry is moved down
//   through the single read port of the entry memory; full or empty answers go straight to the result
// one item at a time; the next item can be taken in the cycle after its result is registered,
//   even while that result still waits on the output
// reset clears the entry count and control state; the entry memory needs no clearing pass
module die_aware_command_scheduler #(
    parameter int WINDOW           = dacs_pkg::WINDOW_DEF,
    parameter int STORE_DEPTH      = dacs_pkg::STORE_DEPTH_DEF,
    parameter int DIES             = dacs_pkg::DIES_DEF,
    parameter int SECTORS_PER_PAGE = dacs_pkg::SECTORS_PER_PAGE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dacs_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dacs_pkg::rsp_item_t rsp
);

    import dacs_pkg::*;

    localparam int DW = (DIES > 1) ? $clog2(DIES) : 1;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int MW = DW + ENTRY_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_SH_RD,
        S_SH_WR,
        S_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [DIES-1:0]   claimed_reg, claimed_next;
    logic [7:0]        busy_reg, busy_next;
    entry_t            hold_reg, hold_next;
    status_t           res_status_reg, res_status_next;
    entry_t            res_entry_reg, res_entry_next;
    logic [DW-1:0]     res_die_reg, res_die_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [MW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [MW-1:0]     ram_rdata;

    logic              div_start;
    logic              div_done;
    logic [DW-1:0]     div_die;

    logic [CW-1:0]     limit;
    logic [CW-1:0]     idx_inc;
    logic [DW-1:0]     rd_die;
    entry_t            rd_entry;
    logic              rd_die_busy;

    dacs_ram #(
        .WIDTH (MW),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dacs_die_calc #(
        .SECTORS_PER_PAGE (SECTORS_PER_PAGE),
        .DIES             (DIES),
        .DW               (DW)
    ) u_die_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .sector (cmd.sector_addr),
        .done   (div_done),
        .die    (div_die)
    );

    assign limit    = (int'(count_reg) < WINDOW) ? count_reg : CW'(WINDOW);
    assign idx_inc  = idx_reg + CW'(1);
    assign rd_die   = ram_rdata[MW-1 -: DW];
    assign rd_entry = entry_t'(ram_rdata[ENTRY_W-1:0]);

    // dies past the 8-bit busy map count as idle
    always_comb
    begin
        rd_die_busy = 1'b0;
        for (int b = 0; b < 8; b++)
        begin
            if (int'(rd_die) == b && busy_reg[b])
            begin
                rd_die_busy = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        claimed_next    = claimed_reg;
        busy_next       = busy_reg;
        hold_next       = hold_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_die_next    = res_die_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {div_die, hold_reg};
        ram_raddr = idx_reg[AW-1:0];
        div_start = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_entry_next = '0;
                    res_die_next   = '0;
                    hold_next      = '{op: cmd.cmd_code, sector: cmd.sector_addr,
                                       count: cmd.sector_count, tag: cmd.tag};
                    busy_next      = cmd.die_busy;
                    idx_next       = '0;
                    claimed_next   = '0;
                    if (cmd.func == FUNC_ENQUEUE)
                    begin
                        if (int'(count_reg) >= STORE_DEPTH)
                        begin
                            res_status_next = STAT_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STAT_NONE;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ram_we          = 1'b1;
                    count_next      = count_reg + CW'(1);
                    res_status_next = STAT_ACCEPTED;
                    state_next      = S_RESULT;
                end
            end

            S_RD:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (!claimed_reg[rd_die] && !rd_die_busy)
                begin
                    res_status_next = STAT_ISSUED;
                    res_entry_next  = rd_entry;
                    res_die_next    = rd_die;
                    if (int'(idx_reg) + 1 < int'(count_reg))
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    // an older entry on this die keeps younger ones behind it
                    claimed_next[rd_die] = 1'b1;
                    idx_next = idx_inc;
                    if (int'(idx_reg) + 1 < int'(limit))
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        res_status_next = STAT_NONE;
                        state_next      = S_RESULT;
                    end
                end
            end

            S_SH_RD:
            begin
                ram_raddr  = idx_inc[AW-1:0];
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (int'(idx_reg) + 2 < int'(count_reg))
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next                = 1'b1;
                    rsp_next.status               = res_status_reg;
                    rsp_next.out_cmd_code         = res_entry_reg.op;
                    rsp_next.out_sector_addr      = res_entry_reg.sector;
                    rsp_next.out_sector_count     = res_entry_reg.count;
                    rsp_next.out_tag              = res_entry_reg.tag;
                    rsp_next.out_die              = 3'(res_die_reg);
                    rsp_next.queue_length         = 6'(count_reg);
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        claimed_reg    <= claimed_next;
        busy_reg       <= busy_next;
        hold_reg       <= hold_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_die_reg    <= res_die_next;
        rsp_reg        <= rsp_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/dacs_ram.sv =====
module dacs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dacs_die_calc.sv =====
module dacs_die_calc #(
    parameter int SECTORS_PER_PAGE = dacs_pkg::SECTORS_PER_PAGE_DEF,
    parameter int DIES             = dacs_pkg::DIES_DEF,
    parameter int DW               = (DIES > 1) ? $clog2(DIES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   sector,
    output logic          done,
    output logic [DW-1:0] die
);

    import dacs_pkg::*;

    // ceil(2^(32+l)/d) with 2^l >= d gives an exact quotient for every 32-bit dividend
    function automatic logic [32:0] recip(int d, int l);
        logic [63:0] num;
        num = 64'd1 << (32 + l);
        return 33'((num + 64'(d) - 64'd1) / 64'(d));
    endfunction

    localparam int          L1 = $clog2(SECTORS_PER_PAGE);
    localparam int          L2 = $clog2(DIES);
    localparam logic [32:0] M1 = recip(SECTORS_PER_PAGE, L1);
    localparam logic [32:0] M2 = recip(DIES, L2);

    logic                sec_v_reg;
    logic                page_v_reg;
    logic                quo_v_reg;
    logic                done_reg;
    logic [SECTOR_W-1:0] sec_reg, sec_next;
    logic [SECTOR_W-1:0] page_reg, page_next;
    logic [SECTOR_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]       die_reg, die_next;
    logic [64:0]         page_prod;
    logic [64:0]         quo_prod;

    // page = sector / spp in one stage, then die = page mod dies via a quotient stage and a die stage
    always_comb
    begin
        sec_next  = start ? sector : sec_reg;
        page_prod = 65'(sec_reg) * 65'(M1);
        page_next = SECTOR_W'(page_prod >> (32 + L1));
        quo_prod  = 65'(page_reg) * 65'(M2);
        quo_next  = SECTOR_W'(quo_prod >> (32 + L2));
        // remainder is below dies, so the low bits alone are exact
        die_next  = page_reg[DW-1:0] - quo_reg[DW-1:0] * DW'(DIES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_v_reg  <= 1'b0;
            page_v_reg <= 1'b0;
            quo_v_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            sec_v_reg  <= start;
            page_v_reg <= sec_v_reg;
            quo_v_reg  <= page_v_reg;
            done_reg   <= quo_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg  <= sec_next;
        page_reg <= page_next;
        quo_reg  <= quo_next;
        die_reg  <= die_next;
    end

    assign done = done_reg;
    assign die  = die_reg;

endmodule

// ===== tb/tb_die_aware_command_scheduler.sv =====
module tb_die_aware_command_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import dacs_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 200;

    typedef enum {SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_TWO_DIE} seg_kind_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    cmd_item_t pending_cmds[$];
    rsp_item_t expected_rsp[$];
    entry_t    held_cmds[$];

    int sent_cnt   = 0;
    int acc_cnt    = 0;
    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int mismatches = 0;
    int cycles     = 0;

    die_aware_command_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int die_of_sector(logic [31:0] sector);
        return (sector / SECTORS_PER_PAGE_DEF) % DIES_DEF;
    endfunction

    // busy bit index is channel + way * channels; dies past the bitmap count as idle
    function automatic bit die_busy_now(int die, logic [7:0] busy);
        int chan;
        int way;
        int idx;
        chan = die % CHANNELS_DEF;
        way  = die / CHANNELS_DEF;
        idx  = chan + way * CHANNELS_DEF;
        if (idx >= 8)
            return 1'b0;
        return busy[idx];
    endfunction

    // next result of the scheduler for one item, updates the held command list
    function automatic rsp_item_t schedule_step(cmd_item_t c);
        rsp_item_t  r;
        entry_t     e;
        logic [63:0] claimed;
        int         lim;
        int         d;
        int         i;
        bit         found;
        r        = '0;
        r.status = STAT_NONE;
        if (c.func == FUNC_ENQUEUE)
        begin
            if (held_cmds.size() >= STORE_DEPTH_DEF)
                r.status = STAT_FULL;
            else
            begin
                e.op     = c.cmd_code;
                e.sector = c.sector_addr;
                e.count  = c.sector_count;
                e.tag    = c.tag;
                held_cmds.push_back(e);
                r.status = STAT_ACCEPTED;
            end
        end
        else
        begin
            lim     = (held_cmds.size() < WINDOW_DEF) ? held_cmds.size() : WINDOW_DEF;
            claimed = '0;
            found   = 1'b0;
            for (i = 0; i < lim && !found; i++)
            begin
                d = die_of_sector(held_cmds[i].sector);
                if (!claimed[d] && !die_busy_now(d, c.die_busy))
                begin
                    e                  = held_cmds[i];
                    held_cmds.delete(i);
                    found              = 1'b1;
                    r.status           = STAT_ISSUED;
                    r.out_cmd_code     = e.op;
                    r.out_sector_addr  = e.sector;
                    r.out_sector_count = e.count;
                    r.out_tag          = e.tag;
                    r.out_die          = d[2:0];
                end
                claimed[d] = 1'b1;
            end
        end
        r.queue_length = 6'(held_cmds.size());
        return r;
    endfunction

    function automatic cmd_item_t enq_item(logic [7:0] op, logic [31:0] sec,
                                           logic [7:0] cnt, logic [7:0] tg);
        cmd_item_t c;
        c.func         = FUNC_ENQUEUE;
        c.cmd_code     = op;
        c.sector_addr  = sec;
        c.sector_count = cnt;
        c.tag          = tg;
        c.die_busy     = 8'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t issue_item(logic [7:0] busy);
        cmd_item_t c;
        c.func         = FUNC_ISSUE;
        c.cmd_code     = 8'($urandom);
        c.sector_addr  = $urandom;
        c.sector_count = 8'($urandom);
        c.tag          = 8'($urandom);
        c.die_busy     = busy;
        return c;
    endfunction

    function automatic logic [7:0] busy_map(int pct);
        logic [7:0] m;
        int         b;
        for (b = 0; b < 8; b++)
            m[b] = ($urandom_range(0, 99) < pct);
        return m;
    endfunction

    function automatic cmd_item_t rand_enq(int die);
        logic [31:0] sec;
        sec = $urandom;
        if (die >= 0)
            sec[5:3] = 3'(die);
        return enq_item(8'($urandom), sec, 8'($urandom), 8'($urandom));
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_rsp(rsp_item_t want, rsp_item_t got);
        string bad;
        bad = "";
        if (got.status !== want.status)
            bad = {bad, " status"};
        if (got.out_cmd_code !== want.out_cmd_code)
            bad = {bad, " out_cmd_code"};
        if (got.out_sector_addr !== want.out_sector_addr)
            bad = {bad, " out_sector_addr"};
        if (got.out_sector_count !== want.out_sector_count)
            bad = {bad, " out_sector_count"};
        if (got.out_tag !== want.out_tag)
            bad = {bad, " out_tag"};
        if (got.out_die !== want.out_die)
            bad = {bad, " out_die"};
        if (got.queue_length !== want.queue_length)
            bad = {bad, " queue_length"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t on%s: expected %h actual %h",
                         $realtime, bad, want, got);
        end
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || acc_cnt == sent_cnt))
        begin
            if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                sent_cnt  <= sent_cnt + 1;
                send_gap  <= ((sent_cnt / 128) % 4 == 2) ? 0 : pick_gap();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && acc_cnt >= HOLD_AT)
        begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ((acc_cnt / 96) % 5 != 3 && $urandom_range(0, 99) < 30)
                stall_left <= pick_gap();
        end
    end

    // results are checked before the item taken at the same edge is predicted
    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: %h", $realtime, rsp);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_rsp(want, rsp);
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                expected_rsp.push_back(schedule_step(cmd));
                acc_cnt <= acc_cnt + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        seg_kind_t kind;
        int        densities[4];
        int        n_target;
        int        n_items;
        int        da;
        int        db;
        densities = '{0, 25, 50, 90};

        // directed: empty store, field extremes, busy dies, same-die ordering
        pending_cmds.push_back(issue_item(8'h00));
        pending_cmds.push_back(enq_item(8'h00, 32'h0000_0000, 8'h00, 8'h00));
        pending_cmds.push_back(enq_item(8'hff, 32'hffff_ffff, 8'hff, 8'hff));
        pending_cmds.push_back(issue_item(8'hff));
        pending_cmds.push_back(issue_item(8'h01));
        pending_cmds.push_back(issue_item(8'h00));
        pending_cmds.push_back(issue_item(8'h00));
        pending_cmds.push_back(enq_item(8'h11, 32'h0000_0008, 8'h01, 8'h01));
        pending_cmds.push_back(enq_item(8'h22, 32'h0000_0048, 8'h02, 8'h02));
        pending_cmds.push_back(enq_item(8'h33, 32'h0000_0010, 8'h03, 8'h03));
        pending_cmds.push_back(issue_item(8'h02));
        pending_cmds.push_back(issue_item(8'h00));
        pending_cmds.push_back(issue_item(8'h00));
        pending_cmds.push_back(issue_item(8'h00));

        n_target = pending_cmds.size() + RANDOM_ITEMS;
        while (pending_cmds.size() < n_target)
        begin
            kind = seg_kind_t'($urandom_range(0, 3));
            case (kind)
                SEG_MIXED:
                    repeat ($urandom_range(20, 40))
                    begin
                        if ($urandom_range(0, 99) < 55)
                            pending_cmds.push_back(rand_enq(-1));
                        else
                            pending_cmds.push_back(
                                issue_item(busy_map(densities[$urandom_range(0, 3)])));
                    end
                SEG_FILL:
                    repeat (36)
                        pending_cmds.push_back(rand_enq(-1));
                SEG_DRAIN:
                    repeat ($urandom_range(20, 40))
                        pending_cmds.push_back(issue_item(busy_map($urandom_range(0, 30))));
                default:
                begin
                    // two dies only, so the window fills with blocked entries
                    da = $urandom_range(0, 7);
                    db = $urandom_range(0, 7);
                    repeat ($urandom_range(16, 24))
                        pending_cmds.push_back(rand_enq(($urandom_range(0, 99) < 70) ? da : db));
                    repeat ($urandom_range(8, 20))
                        pending_cmds.push_back(issue_item(busy_map(20) |
                            (($urandom_range(0, 1) == 1) ? (8'h01 << da) : 8'h00)));
                end
            endcase
        end
        n_items = pending_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (acc_cnt < n_items)
            @(posedge clk);
        while (expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
